// ----- rtl/pdap_pkg.sv -----
// Shared types, constants and helper functions of the pickup-delivery arc and path filter.
`default_nettype none
package pdap_pkg;

  localparam int DEF_MAX_REQUESTS = 64;
  localparam int NODE_W           = 8;
  localparam int VAL_W            = 16;
  localparam int NREQ_W           = 7;
  localparam int CFG_IDX_W        = 1;
  localparam int SUM_W            = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REQUESTS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_CAPACITY = 1'd1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ARC  = 2'd1,
    CMD_PATH = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_c;
    logic              bad;
    logic              has_result;
  } item_t;

  function automatic logic [VAL_W-1:0] min16(input logic [VAL_W-1:0] x,
                                             input logic [VAL_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic int cnt_width(input int max_req);
    int w;
    w = $clog2(max_req + 1);
    return (w > NREQ_W) ? w : NREQ_W;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pdap_core.sv -----
// Top level of the pickup-delivery arc and 3-path filter: tables, pipeline and config.
//
// Filter for a pickup and delivery tour. Node 0 is the start depot, 1..n the
// pickups, n+1..2n the matching deliveries, 2n+1 the end depot. A load item
// (cmd 0) writes one node's demand and draught and gives a result only when
// the node is out of range. An arc item (cmd 1) or path item (cmd 2) always
// gives one result: rejected, and bad_node for an out-of-range node (for a
// path item also a depot). cmd 3 is dropped. One item is taken every cycle
// while in_stall is low; a result passes from the registered table read
// (three copies of each table, one read port per node field) through the
// rule logic into the output register. A load is visible to the item
// accepted right after it. Reads of entries never loaded give undefined
// flags. Write configuration only while idle; num_requests 0 acts as 1 and
// values above MAX_REQUESTS act as MAX_REQUESTS. num_requests keeps cfg_data[6:0].
`default_nettype none
module pickup_delivery_arc_path_filter_core #(
  parameter int MAX_REQUESTS = pdap_pkg::DEF_MAX_REQUESTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_cmd,
  input  wire logic [pdap_pkg::NODE_W-1:0]       in_node_a,
  input  wire logic [pdap_pkg::NODE_W-1:0]       in_node_b,
  input  wire logic [pdap_pkg::NODE_W-1:0]       in_node_c,
  input  wire logic signed [pdap_pkg::VAL_W-1:0] in_node_demand,
  input  wire logic [pdap_pkg::VAL_W-1:0]        in_node_draught,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_rejected,
  output logic                                   out_bad_node,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pdap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pdap_pkg::VAL_W-1:0]        cfg_data
);

  localparam int CW    = pdap_pkg::cnt_width(MAX_REQUESTS);
  localparam int LW    = CW + 2;
  localparam int DEPTH = 2 * MAX_REQUESTS + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = pdap_pkg::VAL_W;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_REQUESTS);

  logic [pdap_pkg::NREQ_W-1:0] nreq_r;
  logic [VW-1:0]               cap_r;
  logic [CW-1:0]               n_ext, n_eff;
  logic [LW-1:0]               n_l, two_n_l, top_l;
  logic [LW-1:0]               a_l, b_l, c_l;

  pdap_pkg::cmd_t  cmd_in;
  pdap_pkg::item_t item_in;
  pdap_pkg::item_t s1_item_r;
  logic            s1_valid_r;
  logic            out_valid_r, out_rejected_r, out_bad_node_r;
  logic            out_free, s1_free, in_accept, ram_we, rej_s1;

  logic [AW-1:0] waddr;
  logic [AW-1:0] dem_addr [3];
  logic [AW-1:0] dra_addr [3];
  logic [VW-1:0] dem_q    [3];
  logic [VW-1:0] dra_q    [3];
  logic [LW-1:0] node_l   [3];

  function automatic logic [AW-1:0] to_addr(input logic [LW-1:0] x);
    return x[AW-1:0];
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nreq_r <= pdap_pkg::NREQ_W'(1);
      cap_r  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == pdap_pkg::CFG_NUM_REQUESTS) begin
        nreq_r <= cfg_data[pdap_pkg::NREQ_W-1:0];
      end else if (cfg_index == pdap_pkg::CFG_VEHICLE_CAPACITY) begin
        cap_r <= cfg_data;
      end
    end
  end

  assign n_ext   = CW'(nreq_r);
  assign n_eff   = (n_ext == '0) ? CW'(1) : ((n_ext > MAX_N) ? MAX_N : n_ext);
  assign n_l     = LW'(n_eff);
  assign two_n_l = n_l + n_l;
  assign top_l   = two_n_l + LW'(1);

  // input decode
  assign a_l    = LW'(in_node_a);
  assign b_l    = LW'(in_node_b);
  assign c_l    = LW'(in_node_c);
  assign cmd_in = pdap_pkg::cmd_t'(in_cmd);

  always_comb begin
    item_in.cmd    = cmd_in;
    item_in.node_a = in_node_a;
    item_in.node_b = in_node_b;
    item_in.node_c = in_node_c;
    unique case (cmd_in)
      pdap_pkg::CMD_LOAD: begin
        item_in.bad        = a_l > top_l;
        item_in.has_result = a_l > top_l;
      end
      pdap_pkg::CMD_ARC: begin
        item_in.bad        = (a_l > top_l) || (b_l > top_l);
        item_in.has_result = 1'b1;
      end
      pdap_pkg::CMD_PATH: begin
        item_in.bad        = (a_l == '0) || (a_l > two_n_l) ||
                             (b_l == '0) || (b_l > two_n_l) ||
                             (c_l == '0) || (c_l > two_n_l);
        item_in.has_result = 1'b1;
      end
      default: begin
        item_in.bad        = 1'b0;
        item_in.has_result = 1'b0;
      end
    endcase
  end

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;
  assign ram_we    = in_accept && (cmd_in == pdap_pkg::CMD_LOAD) && !item_in.bad;
  assign waddr     = to_addr(a_l);

  assign node_l[0] = a_l;
  assign node_l[1] = b_l;
  assign node_l[2] = c_l;

  // tables, one copy per node field
  for (genvar p = 0; p < 3; p++) begin : g_port
    always_comb begin
      dra_addr[p] = to_addr(node_l[p]);
      if ((cmd_in == pdap_pkg::CMD_PATH) && (node_l[p] > n_l)) begin
        dem_addr[p] = to_addr(node_l[p] - n_l);
      end else begin
        dem_addr[p] = to_addr(node_l[p]);
      end
    end

    pdap_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_dem (
      .clk   (clk),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (in_node_demand),
      .re    (in_accept),
      .raddr (dem_addr[p]),
      .rdata (dem_q[p])
    );

    pdap_ram #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_dra (
      .clk   (clk),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (in_node_draught),
      .re    (in_accept),
      .raddr (dra_addr[p]),
      .rdata (dra_q[p])
    );
  end

  // stage 1: registered item next to the table reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= item_in;
    end
  end

  pdap_eval #(.MAX_REQUESTS(MAX_REQUESTS)) u_eval (
    .item     (s1_item_r),
    .n_l      (n_l),
    .cap      (cap_r),
    .dem_a    (dem_q[0]),
    .dem_b    (dem_q[1]),
    .dem_c    (dem_q[2]),
    .dra_a    (dra_q[0]),
    .dra_b    (dra_q[1]),
    .dra_c    (dra_q[2]),
    .rejected (rej_s1)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_item_r.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_rejected_r <= rej_s1;
      out_bad_node_r <= s1_item_r.bad;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_rejected = out_rejected_r;
  assign out_bad_node = out_bad_node_r;

endmodule
`default_nettype wire

// ----- rtl/pdap_ram.sv -----
// Table memory with one write port and one registered read port.
`default_nettype none
module pdap_ram #(
  parameter int DEPTH = 130,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pdap_eval.sv -----
// Arc and 3-path rejection rules evaluated on the registered item and table reads.
`default_nettype none
module pdap_eval #(
  parameter int MAX_REQUESTS = pdap_pkg::DEF_MAX_REQUESTS,
  localparam int CW = pdap_pkg::cnt_width(MAX_REQUESTS),
  localparam int LW = CW + 2
) (
  input  wire pdap_pkg::item_t                item,
  input  wire logic [LW-1:0]                  n_l,
  input  wire logic [pdap_pkg::VAL_W-1:0]     cap,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dem_a,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dem_b,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dem_c,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dra_a,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dra_b,
  input  wire logic [pdap_pkg::VAL_W-1:0]     dra_c,
  output logic                                rejected
);

  localparam int SW = pdap_pkg::SUM_W;

  logic [LW-1:0] i_l, j_l, k_l, top_l;
  logic          ip, jp, kp;
  logic signed [pdap_pkg::VAL_W-1:0] da_s, db_s, dc_s;
  logic signed [SW-1:0] da, db, dc, abs_a, abs_b;
  logic signed [SW-1:0] arc_pp, arc_pd, arc_dd, s3, s2;
  logic [pdap_pkg::VAL_W-1:0] m_qb_u, m_qab_u, m_qa_u, m_qc_u, m_qbc_u;
  logic signed [SW-1:0] m_qb, m_qab, m_qa, m_qc, m_qbc;
  logic arc_rej, path_rej;

  assign i_l   = LW'(item.node_a);
  assign j_l   = LW'(item.node_b);
  assign k_l   = LW'(item.node_c);
  assign top_l = n_l + n_l + LW'(1);
  assign ip    = i_l <= n_l;
  assign jp    = j_l <= n_l;
  assign kp    = k_l <= n_l;

  assign da_s  = dem_a;
  assign db_s  = dem_b;
  assign dc_s  = dem_c;
  assign da    = SW'(da_s);
  assign db    = SW'(db_s);
  assign dc    = SW'(dc_s);
  assign abs_a = (da < 0) ? -da : da;
  assign abs_b = (db < 0) ? -db : db;

  assign m_qa_u  = pdap_pkg::min16(cap, dra_a);
  assign m_qb_u  = pdap_pkg::min16(cap, dra_b);
  assign m_qc_u  = pdap_pkg::min16(cap, dra_c);
  assign m_qab_u = pdap_pkg::min16(m_qa_u, dra_b);
  assign m_qbc_u = pdap_pkg::min16(m_qb_u, dra_c);
  assign m_qa    = SW'(m_qa_u);
  assign m_qb    = SW'(m_qb_u);
  assign m_qc    = SW'(m_qc_u);
  assign m_qab   = SW'(m_qab_u);
  assign m_qbc   = SW'(m_qbc_u);

  assign arc_pp = da + db;
  assign arc_pd = da + abs_b;
  assign arc_dd = abs_a + abs_b;
  assign s3     = da + db + dc;
  assign s2     = da + dc;

  always_comb begin
    arc_rej = (i_l == top_l) || (i_l == j_l) || (j_l == '0) ||
              ((i_l == '0) && !jp) || ((j_l == top_l) && ip) ||
              (i_l == j_l + n_l) ||
              (ip && jp && (arc_pp > m_qb)) ||
              (ip && !jp && (j_l != i_l + n_l) && (arc_pd > m_qab)) ||
              (!ip && !jp && (arc_dd > m_qa));
  end

  always_comb begin
    if (i_l == n_l + k_l) begin
      path_rej = 1'b1;
    end else if (ip) begin
      priority if (jp && kp) begin
        path_rej = s3 > m_qc;
      end else if (jp) begin
        path_rej = (k_l != n_l + i_l) && (k_l != n_l + j_l) &&
                   ((s3 > m_qbc) || (s2 > m_qc));
      end else if (kp) begin
        path_rej = (j_l != n_l + i_l) && (s2 > m_qc);
      end else begin
        path_rej = (j_l != n_l + i_l) && (k_l != n_l + i_l) &&
                   ((s3 > m_qab) || (s2 > m_qc));
      end
    end else if (kp) begin
      path_rej = 1'b0;
    end else if (jp) begin
      path_rej = (k_l != n_l + j_l) && (s2 > m_qa);
    end else begin
      path_rej = s3 > m_qa;
    end
  end

  always_comb begin
    unique case (item.cmd)
      pdap_pkg::CMD_ARC:  rejected = item.bad || arc_rej;
      pdap_pkg::CMD_PATH: rejected = item.bad || path_rej;
      default:            rejected = item.bad;
    endcase
  end

endmodule
`default_nettype wire
